FILE: rtl/hpd_pkg.sv
// Shared types and constants of the hex preview pixel decoder.
`timescale 1ns / 1ps

package hpd_pkg;

   localparam int DEFAULT_MAX_DIM = 4096;

   localparam int DIM_CFG_W = 13;
   localparam int BUDGET_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int POS_W     = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EIGHT_BIT_MODE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCANLINE_BUDGET = 2'd3;

   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_LF      = 8'h0a;
   localparam logic [7:0] CHAR_CR      = 8'h0d;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [3:0] NIBBLE_MASK  = 4'hf;

   typedef enum logic [1:0] {
      CK_HEX,
      CK_SKIP,
      CK_LF,
      CK_BAD
   } char_kind_type;

   typedef struct packed {
      char_kind_type kind;
      logic [3:0]    nibble;   // already inverted
   } char_info_type;

   // Control from the front end to the pixel emitter.
   typedef struct packed {
      logic       load;         // start emitting a result run
      logic       is_err;       // the run is a single error result
      logic [7:0] pix_byte;
      logic       eight_bit;
      logic       frame_start;  // clear the raster counters
   } emit_ctl_type;

   // Status from the pixel emitter back to the front end.
   typedef struct packed {
      logic busy;
      logic finishing;   // last result of the run leaves this cycle
      logic done_evt;    // the pixel leaving this cycle completes the image
   } emit_sts_type;

   typedef struct packed {
      logic             pixel_white;
      logic [POS_W-1:0] pixel_col;
      logic [POS_W-1:0] pixel_row;
      logic             last_of_run;
      logic             frame_done;
      logic             decode_error;
   } result_type;

endpackage

FILE: rtl/hpd_char_decode.sv
// Classifies one preview character and converts hex digits to inverted nibbles.
`timescale 1ns / 1ps

module hpd_char_decode (
   input  logic [7:0]             char_byte,
   output hpd_pkg::char_info_type info
);

   always_comb begin
      info.kind   = hpd_pkg::CK_BAD;
      info.nibble = '0;
      unique case (char_byte) inside
         [hpd_pkg::CHAR_ZERO:hpd_pkg::CHAR_NINE]: begin
            info.kind   = hpd_pkg::CK_HEX;
            info.nibble = 4'(char_byte - hpd_pkg::CHAR_ZERO) ^ hpd_pkg::NIBBLE_MASK;
         end
         [hpd_pkg::CHAR_UPPER_A:hpd_pkg::CHAR_UPPER_F]: begin
            info.kind   = hpd_pkg::CK_HEX;
            info.nibble = 4'(char_byte - hpd_pkg::CHAR_UPPER_A + 8'd10)
                          ^ hpd_pkg::NIBBLE_MASK;
         end
         [hpd_pkg::CHAR_LOWER_A:hpd_pkg::CHAR_LOWER_F]: begin
            info.kind   = hpd_pkg::CK_HEX;
            info.nibble = 4'(char_byte - hpd_pkg::CHAR_LOWER_A + 8'd10)
                          ^ hpd_pkg::NIBBLE_MASK;
         end
         hpd_pkg::CHAR_TAB, hpd_pkg::CHAR_CR, hpd_pkg::CHAR_SPACE,
         hpd_pkg::CHAR_PERCENT: begin
            info.kind = hpd_pkg::CK_SKIP;
         end
         hpd_pkg::CHAR_LF: begin
            info.kind = hpd_pkg::CK_LF;
         end
         default: begin
            info.kind = hpd_pkg::CK_BAD;
         end
      endcase
   end

endmodule

FILE: rtl/hpd_pixel_emitter.sv
// Emits one pixel per cycle from a packed byte while the receiver does not stall, and keeps the raster counters.
`timescale 1ns / 1ps

module hpd_pixel_emitter #(
   parameter int MAX_DIM = hpd_pkg::DEFAULT_MAX_DIM,
   localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hpd_pkg::emit_ctl_type ctl,
   input  logic [DIM_W-1:0]     width_dim,
   input  logic [DIM_W-1:0]     height_dim,
   output hpd_pkg::emit_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hpd_pkg::result_type  rsp_data
);

   logic                act_ff, act_in;
   logic                err_ff, err_in;
   logic [7:0]          byte_ff, byte_in;
   logic [2:0]          bit_ff, bit_in;
   logic                eight_ff, eight_in;
   logic [DIM_W-1:0]    col_ff, col_in;
   logic [DIM_W-1:0]    row_ff, row_in;
   logic                rsp_valid_ff, rsp_valid_in;
   hpd_pkg::result_type rsp_ff, rsp_in;

   logic             out_free, fire;
   logic [DIM_W-1:0] col_inc, row_inc;
   logic             row_end, img_end, stop, white;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = act_ff && out_free;
   assign col_inc  = col_ff + DIM_W'(1);
   assign row_inc  = row_ff + DIM_W'(1);
   assign row_end  = col_inc >= width_dim;
   assign img_end  = row_end && (row_inc >= height_dim);
   assign stop     = err_ff || row_end || eight_ff || (bit_ff == 3'd0);
   assign white    = eight_ff ? (|byte_ff) : byte_ff[bit_ff];

   always_comb begin
      act_in       = act_ff;
      err_in       = err_ff;
      byte_in      = byte_ff;
      bit_in       = bit_ff;
      eight_in     = eight_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (fire) begin
         rsp_valid_in = 1'b1;
         if (err_ff) begin
            rsp_in = '{pixel_white: 1'b0, pixel_col: '0, pixel_row: '0,
                       last_of_run: 1'b1, frame_done: 1'b0, decode_error: 1'b1};
         end else begin
            rsp_in = '{pixel_white: white,
                       pixel_col: hpd_pkg::POS_W'(col_ff),
                       pixel_row: hpd_pkg::POS_W'(row_ff),
                       last_of_run: stop, frame_done: img_end, decode_error: 1'b0};
            if (row_end) begin
               col_in = '0;
               row_in = row_inc;
            end else begin
               col_in = col_inc;
            end
         end
         if (stop) begin
            act_in = 1'b0;
         end else begin
            bit_in = bit_ff - 3'd1;
         end
      end

      // A new run may start in the cycle the previous one finishes.
      if (ctl.load) begin
         act_in   = 1'b1;
         err_in   = ctl.is_err;
         byte_in  = ctl.pix_byte;
         bit_in   = 3'd7;
         eight_in = ctl.eight_bit;
      end
      if (ctl.frame_start) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
      err_ff   <= err_in;
      byte_ff  <= byte_in;
      bit_ff   <= bit_in;
      eight_ff <= eight_in;
      rsp_ff   <= rsp_in;
   end

   assign sts.busy      = act_ff;
   assign sts.finishing = fire && stop;
   assign sts.done_evt  = fire && !err_ff && img_end;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

FILE: rtl/hex_preview_pixel_decoder.sv
// Top level of the hex preview pixel decoder: front end, registers and emitter.
`timescale 1ns / 1ps

// The block turns the hex text of a preview image into pixels in raster order.
// Characters arrive on the req_ channel (valid/stall); a transaction with
// req_cmd high starts a new frame, otherwise req_data_byte is one character.
// Pixels and error results leave on the rsp_ channel, one per transaction.
// The csr_ port writes the width, height, mode and line feed budget; the user
// must write it only while the block is idle, which the block does not enforce.
// The second hex digit of a byte loads the emitter's run registers, and the
// emitter then registers the first pixel of the byte in the result register.
// A character that gives no result starts no run, so it does not stall the
// input. A completed byte is emitted one pixel per cycle by the emitter while
// the receiver does not stall, up to eight pixels in 1-bit mode and one in
// 8-bit mode, and the input is stalled while a run is in flight except in the
// cycle its last result leaves; the emitter's pixel rate sets the input rate.
// When the receiver stalls, the result register holds, the emitter holds,
// and req_stall stays high while a run waits. Reset clears the registers to
// their defaults and puts the block into idle, where data characters are
// ignored until a frame start arrives. After an error result the block stops
// until the next frame start.
module hex_preview_pixel_decoder #(
   parameter int MAX_DIM = hpd_pkg::DEFAULT_MAX_DIM
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_pixel_white,
   output logic [hpd_pkg::POS_W-1:0]      rsp_pixel_col,
   output logic [hpd_pkg::POS_W-1:0]      rsp_pixel_row,
   output logic                           rsp_last_of_run,
   output logic                           rsp_frame_done,
   output logic                           rsp_decode_error,
   input  logic                           csr_we,
   input  logic [hpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hpd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RUN,
      PH_DONE,
      PH_STOP
   } phase_type;

   // Registers written through the configuration port.
   logic [hpd_pkg::DIM_CFG_W-1:0] width_ff;
   logic [hpd_pkg::DIM_CFG_W-1:0] height_ff;
   logic                          eight_ff;
   logic [hpd_pkg::BUDGET_W-1:0]  budget_ff;

   phase_type                    phase_ff, phase_in, phase_now;
   logic [7:0]                   acc_ff, acc_in;
   logic                         pend_ff, pend_in;
   logic [hpd_pkg::BUDGET_W-1:0] lines_ff, lines_in;

   hpd_pkg::char_info_type info;
   hpd_pkg::emit_ctl_type  ctl;
   hpd_pkg::emit_sts_type  sts;
   hpd_pkg::result_type    rsp_data;

   logic             req_accept;
   logic [DIM_W-1:0] width_dim, height_dim;

   // Out of range dimensions: zero counts as one, above MAX_DIM as MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [hpd_pkg::DIM_CFG_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end else begin
         return DIM_W'(v);
      end
   endfunction

   assign width_dim  = clamp_dim(width_ff);
   assign height_dim = clamp_dim(height_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= hpd_pkg::DIM_CFG_W'(1);
         height_ff <= hpd_pkg::DIM_CFG_W'(1);
         eight_ff  <= 1'b0;
         budget_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            hpd_pkg::CSR_IMAGE_WIDTH:     width_ff  <= csr_wdata[hpd_pkg::DIM_CFG_W-1:0];
            hpd_pkg::CSR_IMAGE_HEIGHT:    height_ff <= csr_wdata[hpd_pkg::DIM_CFG_W-1:0];
            hpd_pkg::CSR_EIGHT_BIT_MODE:  eight_ff  <= csr_wdata[0];
            hpd_pkg::CSR_SCANLINE_BUDGET: budget_ff <= csr_wdata[hpd_pkg::BUDGET_W-1:0];
            default: ;
         endcase
      end
   end

   hpd_char_decode u_decode (
      .char_byte (req_data_byte),
      .info      (info)
   );

   // The next transaction may enter in the cycle the last result of a run leaves.
   assign req_stall  = sts.busy && !sts.finishing;
   assign req_accept = req_valid && !req_stall;

   // The pixel that completes the image this cycle ends the frame at once,
   // so a character accepted in the same cycle already sees it.
   assign phase_now = sts.done_evt ? PH_DONE : phase_ff;

   always_comb begin
      phase_in = phase_now;
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      lines_in = lines_ff;
      ctl      = '{load: 1'b0, is_err: 1'b0, pix_byte: acc_ff,
                   eight_bit: eight_ff, frame_start: 1'b0};

      if (req_accept) begin
         if (req_cmd) begin
            phase_in        = PH_RUN;
            acc_in          = '0;
            pend_in         = 1'b0;
            lines_in        = budget_ff;
            ctl.frame_start = 1'b1;
         end else if (phase_now == PH_RUN) begin
            case (info.kind)
               hpd_pkg::CK_LF: begin
                  if (lines_ff == '0) begin
                     phase_in   = PH_STOP;
                     pend_in    = 1'b0;
                     ctl.load   = 1'b1;
                     ctl.is_err = 1'b1;
                  end else begin
                     lines_in = lines_ff - hpd_pkg::BUDGET_W'(1);
                  end
               end
               hpd_pkg::CK_HEX: begin
                  acc_in = {acc_ff[3:0], info.nibble};
                  if (pend_ff) begin
                     pend_in      = 1'b0;
                     ctl.load     = 1'b1;
                     ctl.pix_byte = {acc_ff[3:0], info.nibble};
                  end else begin
                     pend_in = 1'b1;
                  end
               end
               hpd_pkg::CK_BAD: begin
                  phase_in   = PH_STOP;
                  pend_in    = 1'b0;
                  ctl.load   = 1'b1;
                  ctl.is_err = 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         pend_ff  <= 1'b0;
         lines_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
         lines_ff <= lines_in;
      end
   end

   hpd_pixel_emitter #(
      .MAX_DIM (MAX_DIM)
   ) u_emitter (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .width_dim  (width_dim),
      .height_dim (height_dim),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_pixel_white  = rsp_data.pixel_white;
   assign rsp_pixel_col    = rsp_data.pixel_col;
   assign rsp_pixel_row    = rsp_data.pixel_row;
   assign rsp_last_of_run  = rsp_data.last_of_run;
   assign rsp_frame_done   = rsp_data.frame_done;
   assign rsp_decode_error = rsp_data.decode_error;

   // An error result carries no pixel and always closes its run.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_decode_error) |->
         (rsp_last_of_run && !rsp_frame_done && !rsp_pixel_white))
      else $error("error result with pixel content");

   // The pixel that completes the image also closes its run.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> rsp_last_of_run)
      else $error("frame done without last of run");

   // Completing the image ends the frame unless a new frame starts at once.
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      (sts.done_evt && !(req_accept && req_cmd)) |=> (phase_ff == PH_DONE))
      else $error("image completed but frame still running");

   // A new run is only loaded when the emitter is free or finishing.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> (!sts.busy || sts.finishing))
      else $error("run loaded over an active run");

endmodule
